/* rtl/tccb_pkg.sv */
package tccb_pkg;

    // Store geometry: row-major, fixed row pitch of MAX_COLS
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 32;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int CELL_W   = 16;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    // Register and comparison widths
    localparam int CFG_W    = 8;
    localparam int TAB_W    = 7;
    localparam int TAB_MAX  = 64;
    localparam int CMP_W    = ((COL_W > TAB_W) ? COL_W : TAB_W) + 1;
    localparam int TAB_CAP  = 2 * MAX_COLS + 2;
    localparam int TCNT_W   = $clog2(TAB_CAP + 1);

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h70;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_TAB     = 2'd2;

    // Clear kinds
    localparam logic [2:0] CLR_ALL        = 3'd0;
    localparam logic [2:0] CLR_TO_END     = 3'd1;
    localparam logic [2:0] CLR_TO_EOL     = 3'd2;
    localparam logic [2:0] CLR_FROM_START = 3'd3;
    localparam logic [2:0] CLR_FROM_SOL   = 3'd4;

    typedef enum logic [3:0] {
        ACT_PUT      = 4'd0,
        ACT_CR       = 4'd1,
        ACT_LF       = 4'd2,
        ACT_BS       = 4'd3,
        ACT_TAB      = 4'd4,
        ACT_MOVE     = 4'd5,
        ACT_CLEAR    = 4'd6,
        ACT_INSLINE  = 4'd7,
        ACT_DELLINE  = 4'd8,
        ACT_INSCHAR  = 4'd9,
        ACT_DELCHAR  = 4'd10,
        ACT_SCROLL   = 4'd11,
        ACT_READ     = 4'd12
    } action_t;

    // Where a copy sweep reads relative to the cell it writes
    typedef enum logic [1:0] {
        SRC_ROW_NEXT = 2'd0,
        SRC_ROW_PREV = 2'd1,
        SRC_COL_NEXT = 2'd2,
        SRC_COL_PREV = 2'd3
    } src_dir_t;

    typedef struct packed {
        logic              copy;
        logic [ROW_W-1:0]  row_first;
        logic [ROW_W-1:0]  row_last;
        logic              row_down;
        logic [COL_W-1:0]  col_first;
        logic [COL_W-1:0]  col_last;
        logic              col_down;
        src_dir_t          src;
        logic [CELL_W-1:0] fill;
    } sweep_cmd_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

/* rtl/tccb_ram.sv */
module tccb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tccb_sweep.sv */
module tccb_sweep
    import tccb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sweep_cmd_t        cmd,
    input  logic [CELL_W-1:0] rdata,
    output mem_req_t          req,
    output logic              busy
);

    logic              active_reg, active_next;
    logic              pend_reg, pend_next;
    sweep_cmd_t        cmd_reg, cmd_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ROW_W-1:0]  src_row;
    logic [COL_W-1:0]  src_col;
    logic              last;

    // Source cell of a copy
    always_comb
    begin
        src_row = row_reg;
        src_col = col_reg;
        unique case (cmd_reg.src)
            SRC_ROW_NEXT: src_row = row_reg + 1'b1;
            SRC_ROW_PREV: src_row = row_reg - 1'b1;
            SRC_COL_NEXT: src_col = col_reg + 1'b1;
            SRC_COL_PREV: src_col = col_reg - 1'b1;
            default:      src_row = row_reg;
        endcase
    end

    assign last = (row_reg == cmd_reg.row_last) && (col_reg == cmd_reg.col_last);

    // Memory request: fill writes directly, copy writes the read data in the next cycle
    always_comb
    begin
        req.raddr = {src_row, src_col};
        req.we    = pend_reg || (active_reg && !cmd_reg.copy);
        req.waddr = pend_reg ? pend_addr_reg : {row_reg, col_reg};
        req.wdata = pend_reg ? rdata : cmd_reg.fill;
    end

    // Walk the box, rows outer, columns inner
    always_comb
    begin
        active_next    = active_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pend_next      = active_reg && cmd_reg.copy;
        pend_addr_next = {row_reg, col_reg};
        if (start)
        begin
            active_next = 1'b1;
            cmd_next    = cmd;
            row_next    = cmd.row_first;
            col_next    = cmd.col_first;
        end
        else if (active_reg)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else if (col_reg == cmd_reg.col_last)
            begin
                col_next = cmd_reg.col_first;
                row_next = cmd_reg.row_down ? row_reg - 1'b1 : row_reg + 1'b1;
            end
            else
            begin
                col_next = cmd_reg.col_down ? col_reg - 1'b1 : col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign busy = active_reg || pend_reg;

    // A pending write only follows a copy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(active_reg && cmd_reg.copy))
        else $error("sweep write-back without a copy read");

endmodule

/* rtl/terminal_character_cell_buffer.sv */
// Cursor-only commands go from dispatch straight to the done state; reads pass a read state first.
// Commands that touch cells write one cell per cycle while the sweep engine runs.
// Tab repeats the put sequence up to 2*MAX_COLS+2 times. One command at a time;
// the next one is accepted while the previous result waits in the output register.
// Reset: in_ready stays low during a pass that fills every cell of the store with 0x7020.
module terminal_character_cell_buffer
    import tccb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [3:0]   action,
    input  logic [7:0]   char_code,
    input  logic [6:0]   target_col,
    input  logic [4:0]   target_row,
    input  logic         option_flag,
    input  logic [2:0]   clear_kind,
    input  logic [7:0]   char_attribute,
    input  logic [7:0]   fill_attribute,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [6:0]   cursor_col,
    output logic [4:0]   cursor_row,
    output logic         wrap_pending,
    output logic [15:0]  cell_value
);

    typedef enum logic [17:0] {
        S_INIT     = 18'h00001,
        S_IDLE     = 18'h00002,
        S_DISPATCH = 18'h00004,
        S_SWEEP    = 18'h00008,
        S_SCR1     = 18'h00010,
        S_SCR2     = 18'h00020,
        S_PUT      = 18'h00040,
        S_PUTW     = 18'h00080,
        S_PUTEND   = 18'h00100,
        S_TABMOD   = 18'h00200,
        S_CLR1     = 18'h00400,
        S_CLR2     = 18'h00800,
        S_INS1     = 18'h01000,
        S_INS2     = 18'h02000,
        S_DEL1     = 18'h04000,
        S_DEL2     = 18'h08000,
        S_READ     = 18'h10000,
        S_DONE     = 18'h20000
    } state_t;

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    state_t            scr_ret_reg, scr_ret_next;
    logic [ROW_W-1:0]  scr_r0_reg, scr_r0_next;
    logic [ROW_W-1:0]  scr_r1_reg, scr_r1_next;
    logic              scr_up_reg, scr_up_next;

    action_t           act_reg;
    logic [7:0]        ch_reg, ca_reg, fa_reg;
    logic [6:0]        tc_reg;
    logic [4:0]        tr_reg;
    logic              opt_reg;
    logic [2:0]        kind_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              wrap_reg, wrap_next;
    logic [COL_W-1:0]  cols_m1_reg, cols_m1_next;
    logic [ROW_W-1:0]  rows_m1_reg, rows_m1_next;
    logic [TAB_W-1:0]  tab_reg, tab_next;
    logic [COL_W-1:0]  tmod_reg, tmod_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic [CELL_W-1:0] val_reg, val_next;

    logic              out_valid_reg, out_valid_next;
    logic [6:0]        ocol_reg;
    logic [4:0]        orow_reg;
    logic              owrap_reg;
    logic [15:0]       oval_reg;
    logic              load_out;

    logic              sweep_start, sweep_busy;
    sweep_cmd_t        sweep_cmd;
    mem_req_t          sweep_req, top_req, ram_req;
    logic [CELL_W-1:0] ram_rdata;

    logic              accept;
    logic [7:0]        put_ch;
    logic              put_vt52;
    logic [CMP_W-1:0]  tmod_inc;
    logic              in_range;
    logic [8:0]        cfg_cols_ext;
    logic [6:0]        cfg_rows_ext;

    function automatic sweep_cmd_t fill_cmd(
        input logic [ROW_W-1:0]  r0,
        input logic [ROW_W-1:0]  r1,
        input logic [COL_W-1:0]  c0,
        input logic [COL_W-1:0]  c1,
        input logic [CELL_W-1:0] v
    );
        sweep_cmd_t cmd;
        cmd           = '0;
        cmd.row_first = r0;
        cmd.row_last  = r1;
        cmd.col_first = c0;
        cmd.col_last  = c1;
        cmd.fill      = v;
        return cmd;
    endfunction

    function automatic sweep_cmd_t copy_cmd(
        input logic [ROW_W-1:0] r0,
        input logic [ROW_W-1:0] r1,
        input logic             rdown,
        input logic [COL_W-1:0] c0,
        input logic [COL_W-1:0] c1,
        input logic             cdown,
        input src_dir_t         src
    );
        sweep_cmd_t cmd;
        cmd           = '0;
        cmd.copy      = 1'b1;
        cmd.row_first = r0;
        cmd.row_last  = r1;
        cmd.row_down  = rdown;
        cmd.col_first = c0;
        cmd.col_last  = c1;
        cmd.col_down  = cdown;
        cmd.src       = src;
        return cmd;
    endfunction

    tccb_sweep u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sweep_start),
        .cmd   (sweep_cmd),
        .rdata (ram_rdata),
        .req   (sweep_req),
        .busy  (sweep_busy)
    );

    // The sweep engine owns the memory while it runs
    assign ram_req = sweep_busy ? sweep_req : top_req;

    tccb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign put_ch   = (act_reg == ACT_TAB) ? BLANK_CHAR : ch_reg;
    assign put_vt52 = (act_reg == ACT_INSCHAR) ? 1'b0 : opt_reg;
    assign tmod_inc = CMP_W'(tmod_reg) + 1'b1;
    assign in_range = (8'(tc_reg) <= 8'(cols_m1_reg)) && (6'(tr_reg) <= 6'(rows_m1_reg));
    assign cfg_cols_ext = {1'b0, cfg_data};
    assign cfg_rows_ext = {1'b0, cfg_data[5:0]};

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        scr_ret_next   = scr_ret_reg;
        scr_r0_next    = scr_r0_reg;
        scr_r1_next    = scr_r1_reg;
        scr_up_next    = scr_up_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        wrap_next      = wrap_reg;
        cols_m1_next   = cols_m1_reg;
        rows_m1_next   = rows_m1_reg;
        tab_next       = tab_reg;
        tmod_next      = tmod_reg;
        tcnt_next      = tcnt_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        sweep_start    = 1'b0;
        sweep_cmd      = '0;
        top_req        = '0;

        unique case (state_reg)
            S_INIT:
            begin
                sweep_start = 1'b1;
                sweep_cmd   = fill_cmd('0, ROW_W'(MAX_ROWS - 1), '0, COL_W'(MAX_COLS - 1),
                                       {RESET_ATTR, BLANK_CHAR});
                ret_next    = S_IDLE;
                state_next  = S_SWEEP;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next   = '0;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next = S_DONE;
                unique case (act_reg)
                    ACT_PUT:
                    begin
                        state_next = S_PUT;
                    end
                    ACT_CR:
                    begin
                        col_next  = '0;
                        wrap_next = 1'b0;
                    end
                    ACT_LF:
                    begin
                        wrap_next = 1'b0;
                        if (row_reg < rows_m1_reg)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            scr_r0_next  = '0;
                            scr_r1_next  = rows_m1_reg;
                            scr_up_next  = 1'b1;
                            scr_ret_next = S_DONE;
                            state_next   = S_SCR1;
                        end
                    end
                    ACT_BS:
                    begin
                        wrap_next = 1'b0;
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                        end
                        else if (opt_reg && row_reg != '0)
                        begin
                            row_next = row_reg - 1'b1;
                            col_next = cols_m1_reg;
                        end
                    end
                    ACT_TAB:
                    begin
                        tmod_next  = col_reg;
                        tcnt_next  = '0;
                        state_next = S_TABMOD;
                    end
                    ACT_MOVE:
                    begin
                        wrap_next = 1'b0;
                        if (in_range)
                        begin
                            col_next = COL_W'(tc_reg);
                            row_next = ROW_W'(tr_reg);
                        end
                    end
                    ACT_CLEAR:
                    begin
                        wrap_next  = 1'b0;
                        state_next = S_CLR1;
                    end
                    ACT_INSLINE, ACT_DELLINE:
                    begin
                        wrap_next    = 1'b0;
                        scr_r0_next  = row_reg;
                        scr_r1_next  = rows_m1_reg;
                        scr_up_next  = (act_reg == ACT_DELLINE);
                        scr_ret_next = S_DONE;
                        state_next   = S_SCR1;
                    end
                    ACT_INSCHAR:
                    begin
                        state_next = S_INS1;
                    end
                    ACT_DELCHAR:
                    begin
                        wrap_next  = 1'b0;
                        state_next = S_DEL1;
                    end
                    ACT_SCROLL:
                    begin
                        scr_r0_next  = '0;
                        scr_r1_next  = rows_m1_reg;
                        scr_up_next  = opt_reg;
                        scr_ret_next = S_DONE;
                        state_next   = S_SCR1;
                    end
                    ACT_READ:
                    begin
                        if (in_range)
                        begin
                            top_req.raddr = {ROW_W'(tr_reg), COL_W'(tc_reg)};
                            state_next    = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SWEEP:
            begin
                if (!sweep_busy)
                begin
                    state_next = ret_reg;
                end
            end

            // Scroll rows r0..r1 by one line: copy, then blank the vacated row
            S_SCR1:
            begin
                if (scr_r0_reg != scr_r1_reg)
                begin
                    sweep_start = 1'b1;
                    if (scr_up_reg)
                    begin
                        sweep_cmd = copy_cmd(scr_r0_reg, scr_r1_reg - 1'b1, 1'b0,
                                             '0, cols_m1_reg, 1'b0, SRC_ROW_NEXT);
                    end
                    else
                    begin
                        sweep_cmd = copy_cmd(scr_r1_reg, scr_r0_reg + 1'b1, 1'b1,
                                             '0, cols_m1_reg, 1'b0, SRC_ROW_PREV);
                    end
                    ret_next   = S_SCR2;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_SCR2;
                end
            end

            S_SCR2:
            begin
                sweep_start = 1'b1;
                sweep_cmd   = fill_cmd(scr_up_reg ? scr_r1_reg : scr_r0_reg,
                                       scr_up_reg ? scr_r1_reg : scr_r0_reg,
                                       '0, cols_m1_reg, {fa_reg, BLANK_CHAR});
                ret_next    = scr_ret_reg;
                state_next  = S_SWEEP;
            end

            // Put: act on a deferred wrap first
            S_PUT:
            begin
                state_next = S_PUTW;
                if (wrap_reg)
                begin
                    col_next  = '0;
                    wrap_next = 1'b0;
                    tmod_next = '0;
                    if (row_reg < rows_m1_reg)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        scr_r0_next  = '0;
                        scr_r1_next  = rows_m1_reg;
                        scr_up_next  = 1'b1;
                        scr_ret_next = S_PUTW;
                        state_next   = S_SCR1;
                    end
                end
            end

            S_PUTW:
            begin
                top_req.we    = 1'b1;
                top_req.waddr = {row_reg, col_reg};
                top_req.wdata = {ca_reg, put_ch};
                state_next    = S_PUTEND;
                if (col_reg == cols_m1_reg)
                begin
                    if (put_vt52)
                    begin
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        col_next  = '0;
                        wrap_next = 1'b0;
                        tmod_next = '0;
                        if (row_reg < rows_m1_reg)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            scr_r0_next  = '0;
                            scr_r1_next  = rows_m1_reg;
                            scr_up_next  = 1'b1;
                            scr_ret_next = S_PUTEND;
                            state_next   = S_SCR1;
                        end
                    end
                end
                else
                begin
                    col_next  = col_reg + 1'b1;
                    tmod_next = (tmod_inc == CMP_W'(tab_reg)) ? '0 : COL_W'(tmod_inc);
                end
            end

            // Tab stops when the column hits a stop or the repeat limit
            S_PUTEND:
            begin
                state_next = S_DONE;
                if (act_reg == ACT_TAB)
                begin
                    tcnt_next = tcnt_reg + 1'b1;
                    if (tmod_reg != '0 && tcnt_next != TCNT_W'(TAB_CAP))
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            // Column modulo tab size by repeated subtraction
            S_TABMOD:
            begin
                if (CMP_W'(tmod_reg) >= CMP_W'(tab_reg))
                begin
                    tmod_next = COL_W'(CMP_W'(tmod_reg) - CMP_W'(tab_reg));
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            // Clear: first the full-row part, then the partial row
            S_CLR1:
            begin
                state_next = S_CLR2;
                unique case (kind_reg)
                    CLR_ALL:
                    begin
                        sweep_start = 1'b1;
                        sweep_cmd   = fill_cmd('0, rows_m1_reg, '0, cols_m1_reg,
                                               {fa_reg, BLANK_CHAR});
                        ret_next    = S_CLR2;
                        state_next  = S_SWEEP;
                    end
                    CLR_TO_END:
                    begin
                        if (row_reg < rows_m1_reg)
                        begin
                            sweep_start = 1'b1;
                            sweep_cmd   = fill_cmd(row_reg + 1'b1, rows_m1_reg, '0,
                                                   cols_m1_reg, {fa_reg, BLANK_CHAR});
                            ret_next    = S_CLR2;
                            state_next  = S_SWEEP;
                        end
                    end
                    CLR_FROM_START:
                    begin
                        if (row_reg != '0)
                        begin
                            sweep_start = 1'b1;
                            sweep_cmd   = fill_cmd('0, row_reg - 1'b1, '0, cols_m1_reg,
                                                   {fa_reg, BLANK_CHAR});
                            ret_next    = S_CLR2;
                            state_next  = S_SWEEP;
                        end
                    end
                    default:
                    begin
                        state_next = S_CLR2;
                    end
                endcase
            end

            S_CLR2:
            begin
                state_next = S_DONE;
                unique case (kind_reg)
                    CLR_TO_END, CLR_TO_EOL:
                    begin
                        sweep_start = 1'b1;
                        sweep_cmd   = fill_cmd(row_reg, row_reg, col_reg, cols_m1_reg,
                                               {fa_reg, BLANK_CHAR});
                        ret_next    = S_DONE;
                        state_next  = S_SWEEP;
                    end
                    CLR_FROM_START, CLR_FROM_SOL:
                    begin
                        if (col_reg != '0)
                        begin
                            sweep_start = 1'b1;
                            sweep_cmd   = fill_cmd(row_reg, row_reg, '0, col_reg - 1'b1,
                                                   {fa_reg, BLANK_CHAR});
                            ret_next    = S_DONE;
                            state_next  = S_SWEEP;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Insert char: shift the line right from the cursor
            S_INS1:
            begin
                state_next = S_INS2;
                if (col_reg < cols_m1_reg)
                begin
                    sweep_start = 1'b1;
                    sweep_cmd   = copy_cmd(row_reg, row_reg, 1'b0, cols_m1_reg,
                                           col_reg + 1'b1, 1'b1, SRC_COL_PREV);
                    ret_next    = S_INS2;
                    state_next  = S_SWEEP;
                end
            end

            S_INS2:
            begin
                top_req.we    = 1'b1;
                top_req.waddr = {row_reg, col_reg};
                top_req.wdata = {ca_reg, opt_reg ? BLANK_CHAR : ch_reg};
                state_next    = opt_reg ? S_DONE : S_PUT;
            end

            // Delete char: shift the line left, append at the last column
            S_DEL1:
            begin
                state_next = S_DEL2;
                if (col_reg < cols_m1_reg)
                begin
                    sweep_start = 1'b1;
                    sweep_cmd   = copy_cmd(row_reg, row_reg, 1'b0, col_reg,
                                           cols_m1_reg - 1'b1, 1'b0, SRC_COL_NEXT);
                    ret_next    = S_DEL2;
                    state_next  = S_SWEEP;
                end
            end

            S_DEL2:
            begin
                top_req.we    = 1'b1;
                top_req.waddr = {row_reg, cols_m1_reg};
                top_req.wdata = {fa_reg, ch_reg};
                state_next    = S_DONE;
            end

            S_READ:
            begin
                val_next   = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // Register writes, with the cursor pulled into the new area
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:
                begin
                    if (cfg_data == '0)
                    begin
                        cols_m1_next = '0;
                    end
                    else if (cfg_cols_ext > 9'(MAX_COLS))
                    begin
                        cols_m1_next = COL_W'(MAX_COLS - 1);
                    end
                    else
                    begin
                        cols_m1_next = COL_W'(cfg_cols_ext - 1'b1);
                    end
                end
                CFG_ROWS:
                begin
                    if (cfg_rows_ext == '0)
                    begin
                        rows_m1_next = '0;
                    end
                    else if (cfg_rows_ext > 7'(MAX_ROWS))
                    begin
                        rows_m1_next = ROW_W'(MAX_ROWS - 1);
                    end
                    else
                    begin
                        rows_m1_next = ROW_W'(cfg_rows_ext - 1'b1);
                    end
                end
                CFG_TAB:
                begin
                    if (cfg_data[6:0] == '0)
                    begin
                        tab_next = TAB_W'(1);
                    end
                    else if (cfg_data[6:0] > 7'(TAB_MAX))
                    begin
                        tab_next = TAB_W'(TAB_MAX);
                    end
                    else
                    begin
                        tab_next = cfg_data[6:0];
                    end
                end
                default:
                begin
                    tab_next = tab_reg;
                end
            endcase
            if (col_next > cols_m1_next)
            begin
                col_next = cols_m1_next;
            end
            if (row_next > rows_m1_next)
            begin
                row_next = rows_m1_next;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ret_reg       <= S_IDLE;
            scr_ret_reg   <= S_DONE;
            scr_r0_reg    <= '0;
            scr_r1_reg    <= '0;
            scr_up_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            wrap_reg      <= 1'b0;
            cols_m1_reg   <= COL_W'(80 - 1);
            rows_m1_reg   <= ROW_W'(24 - 1);
            tab_reg       <= TAB_W'(8);
            tmod_reg      <= '0;
            tcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            scr_ret_reg   <= scr_ret_next;
            scr_r0_reg    <= scr_r0_next;
            scr_r1_reg    <= scr_r1_next;
            scr_up_reg    <= scr_up_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            wrap_reg      <= wrap_next;
            cols_m1_reg   <= cols_m1_next;
            rows_m1_reg   <= rows_m1_next;
            tab_reg       <= tab_next;
            tmod_reg      <= tmod_next;
            tcnt_reg      <= tcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (accept)
        begin
            act_reg  <= action_t'(action);
            ch_reg   <= char_code;
            tc_reg   <= target_col;
            tr_reg   <= target_row;
            opt_reg  <= option_flag;
            kind_reg <= clear_kind;
            ca_reg   <= char_attribute;
            fa_reg   <= fill_attribute;
        end
        if (load_out)
        begin
            ocol_reg  <= 7'(col_reg);
            orow_reg  <= 5'(row_reg);
            owrap_reg <= wrap_reg;
            oval_reg  <= val_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_col   = ocol_reg;
    assign cursor_row   = orow_reg;
    assign wrap_pending = owrap_reg;
    assign cell_value   = oval_reg;

    // Cursor always inside the active area
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= cols_m1_reg) && (row_reg <= rows_m1_reg))
        else $error("cursor outside active area");

    // The sweep engine only runs while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_busy |-> (state_reg == S_SWEEP))
        else $error("sweep running outside wait state");

    // A new sweep is never started on top of a running one
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_start |-> !sweep_busy)
        else $error("sweep started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule
